// ===== src/clfp_pkg.sv =====
// ----------------------------------------------------------------------------
// clfp_pkg: shared definitions for the chat link frame parser
// Phase codes, event codes, escape characters and the parser state and
// result structures used by the decoder and the top level.
// ----------------------------------------------------------------------------
package clfp_pkg;

    // Parse phase codes.
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_ESCAPE  = 3'd1;
    localparam logic [2:0] PH_LENGTH  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_TRAILER = 3'd4;

    // Event codes reported with every word.
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_PAYLOAD   = 3'd1;
    localparam logic [2:0] EV_LEFT      = 3'd2;
    localparam logic [2:0] EV_DONE      = 3'd3;
    localparam logic [2:0] EV_WHO       = 3'd4;
    localparam logic [2:0] EV_HANDSHAKE = 3'd5;
    localparam logic [2:0] EV_ACTIVITY  = 3'd6;

    // Link characters.
    localparam logic [7:0] CH_ESC  = 8'h5C;
    localparam logic [7:0] CH_MSG  = 8'h4D;
    localparam logic [7:0] CH_NAME = 8'h48;
    localparam logic [7:0] CH_PING = 8'h50;
    localparam logic [7:0] CH_WHO  = 8'h57;

    // Parser state carried from word to word.
    typedef struct packed {
        logic [2:0] phase;
        logic       frame_kind;
        logic [7:0] declared_length;
        logic [7:0] bytes_seen;
    } parse_state_t;

    // One result word.
    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] payload_byte;
        logic       is_name_frame;
        logic [6:0] frame_length;
    } parse_result_t;

endpackage

// ===== src/clfp_decode.sv =====
// ----------------------------------------------------------------------------
// clfp_decode: next-state and event logic of the frame parser
// Given the current parser state and one received word, produces the next
// state and the result word. Purely combinational.
// ----------------------------------------------------------------------------
module clfp_decode
    import clfp_pkg::*;
(
    input  parse_state_t  state_cur,
    input  logic [7:0]    rx_byte,
    input  logic          peer_offline,
    output parse_state_t  state_nxt,
    output parse_result_t result
);

    // Phase decoder: one arm per parse phase.
    always_comb
    begin
        state_nxt = state_cur;
        result    = '0;
        unique case (state_cur.phase)
            PH_IDLE:
            begin
                if (rx_byte == CH_ESC)
                begin
                    state_nxt.phase = PH_ESCAPE;
                end
            end
            PH_ESCAPE:
            begin
                if ((rx_byte == CH_MSG) || (rx_byte == CH_NAME))
                begin
                    state_nxt.frame_kind = (rx_byte == CH_NAME);
                    state_nxt.bytes_seen = '0;
                    state_nxt.phase      = PH_LENGTH;
                end
                else if (rx_byte == CH_PING)
                begin
                    state_nxt.phase = PH_TRAILER;
                    if (peer_offline)
                    begin
                        result.event_res = EV_WHO;
                    end
                end
                else if (rx_byte == CH_WHO)
                begin
                    state_nxt.phase  = PH_TRAILER;
                    result.event_res = EV_HANDSHAKE;
                end
                else
                begin
                    // An unknown escape, a second backslash included, is dropped.
                    state_nxt.phase = PH_IDLE;
                end
            end
            PH_LENGTH:
            begin
                state_nxt.declared_length = rx_byte;
                state_nxt.bytes_seen      = '0;
                state_nxt.phase           = PH_PAYLOAD;
                if (rx_byte == 8'd0)
                begin
                    result.event_res = EV_LEFT;
                end
            end
            PH_PAYLOAD:
            begin
                if (state_cur.declared_length[7])
                begin
                    // A negative length drops the frame on this word.
                    state_nxt.phase = PH_IDLE;
                end
                else if (state_cur.bytes_seen < state_cur.declared_length)
                begin
                    state_nxt.bytes_seen = state_cur.bytes_seen + 8'd1;
                    result.event_res     = EV_PAYLOAD;
                    result.payload_byte  = rx_byte;
                    result.is_name_frame = state_cur.frame_kind;
                end
                else
                begin
                    result.event_res     = EV_DONE;
                    result.is_name_frame = state_cur.frame_kind;
                    result.frame_length  = state_cur.declared_length[6:0];
                    state_nxt.phase      = PH_IDLE;
                end
            end
            PH_TRAILER:
            begin
                result.event_res = EV_ACTIVITY;
                state_nxt.phase  = PH_IDLE;
            end
            default:
            begin
                state_nxt.phase = PH_IDLE;
            end
        endcase
    end

endmodule

// ===== src/chat_link_frame_parser.sv =====
// ----------------------------------------------------------------------------
// chat_link_frame_parser: byte-stream parser for the chat link protocol
// Takes one received link word per cycle and reports one event word for it.
// ----------------------------------------------------------------------------
// The parser takes one received byte per clock cycle and returns exactly one
// event word per byte, in order. The event word reaches the output the cycle
// after its byte is accepted when the output side keeps up, and later while
// earlier words wait there. The parser state is updated in the same cycle
// the byte is accepted, so a new byte can follow in every cycle. Results sit
// in an output register backed by a one-word skid register; the input stalls
// only while the skid register holds a word, which keeps full rate whenever
// the output side keeps up.
// ----------------------------------------------------------------------------
module chat_link_frame_parser
    import clfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       peer_offline,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] event_res,
    output logic [7:0] payload_byte,
    output logic       is_name_frame,
    output logic [6:0] frame_length
);

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t new_result;
    parse_result_t out_reg;
    parse_result_t skid_reg;
    logic          out_valid_reg;
    logic          skid_valid_reg;
    logic          in_accept;
    logic          out_take;

    // Handshake decode.
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    // Parser next-state and event logic.
    clfp_decode u_decode
    (
        .state_cur    (state_reg),
        .rx_byte      (rx_byte),
        .peer_offline (peer_offline),
        .state_nxt    (state_next),
        .result       (new_result)
    );

    // Parser state advances on every accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output register and skid register valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_accept;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (out_take && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (in_accept && (out_take || !out_valid_reg))
        begin
            out_reg <= new_result;
        end
        if (in_accept && out_valid_reg && !out_take)
        begin
            skid_reg <= new_result;
        end
    end

    // Output ports.
    assign out_valid     = out_valid_reg;
    assign event_res     = out_reg.event_res;
    assign payload_byte  = out_reg.payload_byte;
    assign is_name_frame = out_reg.is_name_frame;
    assign frame_length  = out_reg.frame_length;

    // The skid register is only ever filled behind a full output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a word while output register is empty");

    // Payload count never passes a non-negative declared length.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg.phase == PH_PAYLOAD) && !state_reg.declared_length[7])
        |-> (state_reg.bytes_seen <= state_reg.declared_length))
        else $error("payload count exceeds declared length");

    // A word taken while the skid is full leaves the output register valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && skid_valid_reg) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid word lost on output transfer");

    // A word accepted with nothing waiting shows up at the output next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (!out_valid_reg || out_take)) |=> out_valid_reg)
        else $error("accepted word did not reach the output register");

endmodule
